// ===== hw/rtl/sm4_block_encrypt_assert.svh =====
// Assertion macros for the SM4 RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef SM4_BLOCK_ENCRYPT_ASSERT_SVH
`define SM4_BLOCK_ENCRYPT_ASSERT_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define SM4_ASSERT_IMP(lbl, ck, rst_n, ant, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ant) |-> (cons)) \
		else $error("sm4 assertion failed");

// Antecedent implies consequent in the next cycle.
`define SM4_ASSERT_NXT(lbl, ck, rst_n, ant, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ant) |=> (cons)) \
		else $error("sm4 assertion failed");

`else

`define SM4_ASSERT_IMP(lbl, ck, rst_n, ant, cons)
`define SM4_ASSERT_NXT(lbl, ck, rst_n, ant, cons)

`endif

`endif

// ===== hw/rtl/sm4_pkg.sv =====
`timescale 1ns / 1ps

package sm4_pkg;

	localparam int unsigned ROUNDS_DEF = 32;
	localparam int unsigned KEY_DEPTH  = 32;
	localparam int unsigned KEY_AW     = 5;
	localparam int unsigned WORD_W     = 32;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ENCRYPT = 1'b1;

	typedef struct packed {
		logic                op;
		logic [KEY_AW-1:0]   key_index;
		logic [WORD_W-1:0]   key_value;
		logic [WORD_W-1:0]   in_word0;
		logic [WORD_W-1:0]   in_word1;
		logic [WORD_W-1:0]   in_word2;
		logic [WORD_W-1:0]   in_word3;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_word0;
		logic [WORD_W-1:0] out_word1;
		logic [WORD_W-1:0] out_word2;
		logic [WORD_W-1:0] out_word3;
	} rsp_t;

	localparam logic [7:0] SBOX_ROM [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	// Byte-wise S-box substitution.
	function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] a);
		return {SBOX_ROM[a[31:24]], SBOX_ROM[a[23:16]], SBOX_ROM[a[15:8]], SBOX_ROM[a[7:0]]};
	endfunction

	// Linear diffusion L(B).
	function automatic logic [WORD_W-1:0] lin(input logic [WORD_W-1:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
			^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

endpackage

// ===== hw/rtl/sm4_block_encrypt.sv =====
`timescale 1ns / 1ps
// Channel  Payload           Handshake          Direction
// req      sm4_pkg::req_t    req_valid/stall    into block
// rsp      sm4_pkg::rsp_t    rsp_valid/stall    out of block
//
// Flow: a load transfer writes the key store in its accept cycle and the
// block is ready again on the next. After an encrypt transfer req_stall stays
// high while the rounds run in turn through the single round unit; each round
// depends on the one before, so no new request is taken until the finished
// block is in the rsp register. The result lands there at the end of the
// last round; if that register still holds an untaken result, the block
// waits in an extra state, with req_stall high, until it drains.
// Reset: arst_n clears the sequencer and rsp_valid; the key store is
// undefined until each entry is loaded.
// Stalls: req_stall is high while a block is in flight. A waiting result does
// not stop new load transfers or the next encrypt from starting.

`include "sm4_block_encrypt_assert.svh"

module sm4_block_encrypt #(
	parameter int unsigned ROUNDS = sm4_pkg::ROUNDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sm4_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sm4_pkg::rsp_t rsp_data
);

	localparam int unsigned AW = sm4_pkg::KEY_AW;
	localparam logic [AW-1:0] LAST_ROUND = AW'(ROUNDS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_WAIT
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              round_q;
	logic [sm4_pkg::WORD_W-1:0] x0_q, x1_q, x2_q, x3_q;
	logic                       rsp_valid_q;
	sm4_pkg::rsp_t              rsp_data_q;

	logic                       req_xfer;
	logic                       key_we;
	logic                       start;
	logic [AW-1:0]              rd_addr;
	logic [sm4_pkg::WORD_W-1:0] rk;
	logic [sm4_pkg::WORD_W-1:0] t;
	logic                       last_round;
	logic                       slot_free;
	logic                       rsp_load;

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign key_we    = req_xfer && (req_data.op == sm4_pkg::OP_LOAD);
	assign start     = req_xfer && (req_data.op == sm4_pkg::OP_ENCRYPT);

	// Prefetch the key for the coming round: round 0 on start, then round+1.
	assign rd_addr = start ? '0 : round_q + 1'b1;

	assign last_round = (round_q == LAST_ROUND);
	// The output register can take a new result when empty or draining now.
	assign slot_free  = !rsp_valid_q || !rsp_stall;
	// A finished block moves into the output register this cycle.
	assign rsp_load   = slot_free
		&& (((state_q == S_RUN) && last_round) || (state_q == S_WAIT));

	sm4_ram #(
		.WIDTH(sm4_pkg::WORD_W),
		.DEPTH(sm4_pkg::KEY_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(req_data.key_index),
		.wdata(req_data.key_value),
		.raddr(rd_addr),
		.rdata(rk)
	);

	sm4_round u_round (
		.x0(x0_q),
		.x1(x1_q),
		.x2(x2_q),
		.x3(x3_q),
		.rk(rk),
		.t (t)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			round_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Load a new result, or drop the old one once its transfer completes.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						x0_q    <= req_data.in_word0;
						x1_q    <= req_data.in_word1;
						x2_q    <= req_data.in_word2;
						x3_q    <= req_data.in_word3;
						round_q <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					// Advance the word window by one round.
					x0_q    <= x1_q;
					x1_q    <= x2_q;
					x2_q    <= x3_q;
					x3_q    <= t;
					round_q <= round_q + 1'b1;
					if (last_round) begin
						if (slot_free) begin
							// Reverse order: newest word first.
							rsp_data_q.out_word0 <= t;
							rsp_data_q.out_word1 <= x3_q;
							rsp_data_q.out_word2 <= x2_q;
							rsp_data_q.out_word3 <= x1_q;
							state_q              <= S_IDLE;
						end else begin
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					// Hold the final words until the output register frees up.
					if (slot_free) begin
						rsp_data_q.out_word0 <= x3_q;
						rsp_data_q.out_word1 <= x2_q;
						rsp_data_q.out_word2 <= x1_q;
						rsp_data_q.out_word3 <= x0_q;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	`SM4_ASSERT_NXT(a_start_busy, clk, arst_n, start, (state_q == S_RUN) && (round_q == '0))
	`SM4_ASSERT_IMP(a_round_range, clk, arst_n, state_q == S_RUN, round_q <= LAST_ROUND)
	`SM4_ASSERT_IMP(a_wait_full, clk, arst_n, state_q == S_WAIT, rsp_valid_q)
	`SM4_ASSERT_IMP(a_rsp_source, clk, arst_n, $rose(rsp_valid_q), $past(state_q != S_IDLE))
	`SM4_ASSERT_NXT(a_load_no_rsp, clk, arst_n, key_we && !rsp_valid_q, !rsp_valid_q)

endmodule

// ===== hw/rtl/sm4_ram.sv =====
`timescale 1ns / 1ps

module sm4_ram #(
	parameter int unsigned WIDTH = sm4_pkg::WORD_W,
	parameter int unsigned DEPTH = sm4_pkg::KEY_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/sm4_round.sv =====
`timescale 1ns / 1ps

module sm4_round (
	input  logic [sm4_pkg::WORD_W-1:0] x0,
	input  logic [sm4_pkg::WORD_W-1:0] x1,
	input  logic [sm4_pkg::WORD_W-1:0] x2,
	input  logic [sm4_pkg::WORD_W-1:0] x3,
	input  logic [sm4_pkg::WORD_W-1:0] rk,
	output logic [sm4_pkg::WORD_W-1:0] t
);

	logic [sm4_pkg::WORD_W-1:0] mix;

	// X[r+4] = X[r] ^ L(tau(X[r+1] ^ X[r+2] ^ X[r+3] ^ rk))
	assign mix = x1 ^ x2 ^ x3 ^ rk;
	assign t   = x0 ^ sm4_pkg::lin(sm4_pkg::tau(mix));

endmodule

// ===== bench/tb_sm4_block_encrypt.sv =====
`timescale 1ns / 1ps

module tb_sm4_block_encrypt;
	import sm4_pkg::*;

	localparam int NUM_ROUNDS   = ROUNDS_DEF;
	// Encrypt holds the round unit for all NUM_ROUNDS rounds, plus one state
	// when the result register is still full; give the tail a wide margin.
	localparam int DRAIN_CYCLES = 4 * NUM_ROUNDS;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 1270;

	// Private copy of the SM4 S-box so a bad table in the package is caught.
	localparam logic [7:0] SM4_SBOX [256] = '{
		'hd6,'h90,'he9,'hfe,'hcc,'he1,'h3d,'hb7,'h16,'hb6,'h14,'hc2,'h28,'hfb,'h2c,'h05,
		'h2b,'h67,'h9a,'h76,'h2a,'hbe,'h04,'hc3,'haa,'h44,'h13,'h26,'h49,'h86,'h06,'h99,
		'h9c,'h42,'h50,'hf4,'h91,'hef,'h98,'h7a,'h33,'h54,'h0b,'h43,'hed,'hcf,'hac,'h62,
		'he4,'hb3,'h1c,'ha9,'hc9,'h08,'he8,'h95,'h80,'hdf,'h94,'hfa,'h75,'h8f,'h3f,'ha6,
		'h47,'h07,'ha7,'hfc,'hf3,'h73,'h17,'hba,'h83,'h59,'h3c,'h19,'he6,'h85,'h4f,'ha8,
		'h68,'h6b,'h81,'hb2,'h71,'h64,'hda,'h8b,'hf8,'heb,'h0f,'h4b,'h70,'h56,'h9d,'h35,
		'h1e,'h24,'h0e,'h5e,'h63,'h58,'hd1,'ha2,'h25,'h22,'h7c,'h3b,'h01,'h21,'h78,'h87,
		'hd4,'h00,'h46,'h57,'h9f,'hd3,'h27,'h52,'h4c,'h36,'h02,'he7,'ha0,'hc4,'hc8,'h9e,
		'hea,'hbf,'h8a,'hd2,'h40,'hc7,'h38,'hb5,'ha3,'hf7,'hf2,'hce,'hf9,'h61,'h15,'ha1,
		'he0,'hae,'h5d,'ha4,'h9b,'h34,'h1a,'h55,'had,'h93,'h32,'h30,'hf5,'h8c,'hb1,'he3,
		'h1d,'hf6,'he2,'h2e,'h82,'h66,'hca,'h60,'hc0,'h29,'h23,'hab,'h0d,'h53,'h4e,'h6f,
		'hd5,'hdb,'h37,'h45,'hde,'hfd,'h8e,'h2f,'h03,'hff,'h6a,'h72,'h6d,'h6c,'h5b,'h51,
		'h8d,'h1b,'haf,'h92,'hbb,'hdd,'hbc,'h7f,'h11,'hd9,'h5c,'h41,'h1f,'h10,'h5a,'hd8,
		'h0a,'hc1,'h31,'h88,'ha5,'hcd,'h7b,'hbd,'h2d,'h74,'hd0,'h12,'hb8,'he5,'hb4,'hb0,
		'h89,'h69,'h97,'h4a,'h0c,'h96,'h77,'h7e,'h65,'hb9,'hf1,'h09,'hc5,'h6e,'hc6,'h84,
		'h18,'hf0,'h7d,'hec,'h3a,'hdc,'h4d,'h20,'h79,'hee,'h5f,'h3e,'hd7,'hcb,'h39,'h48
	};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	sm4_block_encrypt #(.ROUNDS(NUM_ROUNDS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Requests waiting to go out, and ciphertexts the block still owes us.
	req_t pending_q [$];
	rsp_t cipher_q [$];

	// Shadow of the key store, written as loads transfer.
	logic [31:0] key_shadow [32];

	int cyc      = 0;
	int hold_cnt = 0;
	int n_load   = 0;
	int n_enc    = 0;
	int n_rsp    = 0;
	int n_err    = 0;
	int n_holds  = 0;

	wire hold_off = (hold_cnt != 0);

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------
	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Nonlinear substitution followed by linear diffusion: L(tau(a)).
	function automatic logic [31:0] round_mix(input logic [31:0] a);
		logic [31:0] b;
		b = {SM4_SBOX[a[31:24]], SM4_SBOX[a[23:16]], SM4_SBOX[a[15:8]], SM4_SBOX[a[7:0]]};
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic rsp_t cipher_of(input req_t r);
		logic [31:0] x0, x1, x2, x3, nx;
		rsp_t c;
		x0 = r.in_word0;
		x1 = r.in_word1;
		x2 = r.in_word2;
		x3 = r.in_word3;
		for (int i = 0; i < NUM_ROUNDS; i++) begin
			nx = x0 ^ round_mix(x1 ^ x2 ^ x3 ^ key_shadow[i]);
			x0 = x1;
			x1 = x2;
			x2 = x3;
			x3 = nx;
		end
		// Output is the last four words, newest first.
		c.out_word0 = x3;
		c.out_word1 = x2;
		c.out_word2 = x1;
		c.out_word3 = x0;
		return c;
	endfunction

	// Apply one accepted request: update the key shadow or queue a ciphertext.
	function automatic void absorb_request(input req_t r);
		if (r.op == OP_LOAD) begin
			key_shadow[r.key_index] = r.key_value;
			n_load++;
		end else begin
			cipher_q.push_back(cipher_of(r));
			n_enc++;
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Loads carry random plaintext words, which the block must ignore.
	function automatic void push_load(input logic [4:0] idx, input logic [31:0] val);
		req_t r;
		r.op        = OP_LOAD;
		r.key_index = idx;
		r.key_value = val;
		r.in_word0  = $urandom;
		r.in_word1  = $urandom;
		r.in_word2  = $urandom;
		r.in_word3  = $urandom;
		pending_q.push_back(r);
	endfunction

	// Encrypts carry random key fields, which the block must ignore.
	function automatic void push_encrypt(input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w2, input logic [31:0] w3);
		req_t r;
		r.op        = OP_ENCRYPT;
		r.key_index = 5'($urandom);
		r.key_value = $urandom;
		r.in_word0  = w0;
		r.in_word1  = w1;
		r.in_word2  = w2;
		r.in_word3  = w3;
		pending_q.push_back(r);
	endfunction

	// Rewrite the whole key store; mode 0 = all zero, 1 = all ones, else random.
	function automatic void push_rekey(input int mode);
		for (int i = 0; i < 32; i++) begin
			case (mode)
				0: push_load(i[4:0], 32'h0000_0000);
				1: push_load(i[4:0], 32'hffff_ffff);
				default: push_load(i[4:0], $urandom);
			endcase
		end
	endfunction

	// ---------------------------------------------------------------
	// Driver: present one request at a time, with a random gap before each.
	// A zero gap keeps valid high straight into the next transfer.
	// ---------------------------------------------------------------
	int tx_gap   = 0;
	bit tx_burst = 1'b0;

	always @(posedge clk) begin
		bit took;
		took = 1'b0;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				took = 1'b1;
				absorb_request(req_data);
				tx_gap = tx_burst ? 0 : $urandom_range(0, 13);
				// Switch now and then between bursts with no idling and gappy traffic.
				if ($urandom_range(0, 99) < 4)
					tx_burst = !tx_burst;
			end
			if (!req_valid || took) begin
				if (tx_gap != 0) begin
					tx_gap--;
					req_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					req_data  <= pending_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: check each result transfer against the oldest ciphertext,
	// then draw how long to stall the next one.
	// ---------------------------------------------------------------
	int rx_wait  = 0;
	bit rx_burst = 1'b0;

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				n_rsp++;
				if (cipher_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("[%0d] result with nothing outstanding: %h", cyc, rsp_data);
				end else begin
					want = cipher_q.pop_front();
					if (rsp_data.out_word0 !== want.out_word0 ||
					    rsp_data.out_word1 !== want.out_word1 ||
					    rsp_data.out_word2 !== want.out_word2 ||
					    rsp_data.out_word3 !== want.out_word3) begin
						n_err++;
						if (n_err <= 10)
							$display("[%0d] ciphertext mismatch: expected %h %h %h %h, got %h %h %h %h",
								cyc, want.out_word0, want.out_word1, want.out_word2,
								want.out_word3, rsp_data.out_word0, rsp_data.out_word1,
								rsp_data.out_word2, rsp_data.out_word3);
					end
				end
				rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
				if ($urandom_range(0, 99) < 4)
					rx_burst = !rx_burst;
			end else if (rsp_valid && rx_wait != 0) begin
				rx_wait--;
			end
			rsp_stall <= hold_off || (rx_wait != 0);
		end
	end

	// Long receiver hold-offs while the sender keeps offering: the result
	// register fills, the next block finishes behind it and the input stalls.
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (cyc == 8000 || cyc == 25000) begin
			hold_cnt <= HOLD_CYCLES;
			n_holds++;
		end
	end

	always @(posedge clk)
		cyc <= cyc + 1;

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		bit timed_out;

		// Every key must be written before the first encrypt reads it.
		for (int i = 0; i < 32; i++) begin
			if (i == 0)
				push_load(i[4:0], 32'h0000_0000);
			else if (i == 31)
				push_load(i[4:0], 32'hffff_ffff);
			else
				push_load(i[4:0], $urandom);
		end

		// Directed plaintexts: extremes, the standard test pattern, alternating and single-bit patterns.
		push_encrypt(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		push_encrypt(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		push_encrypt(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
		push_encrypt(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
		push_encrypt(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
		// Rewrite keys right after an encrypt and use them at once.
		push_load(5'd0, 32'hffff_ffff);
		push_load(5'd31, 32'h0000_0000);
		push_encrypt(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
		push_encrypt(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);

		// Random traffic, mostly encrypts, with whole-store rekeys at the
		// all-zero and all-ones extremes and one with random keys.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 350)
				push_rekey(0);
			else if (n == 700)
				push_rekey(1);
			else if (n == 1050)
				push_rekey(2);
			if ($urandom_range(0, 3) == 0)
				push_load(5'($urandom), rand_word());
			else
				push_encrypt(rand_word(), rand_word(), rand_word(), rand_word());
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent and every ciphertext back, then let the tail settle.
		while ((pending_q.size() != 0 || req_valid || cipher_q.size() != 0)
		       && cyc < CYCLE_LIMIT)
			@(posedge clk);
		timed_out = (cyc >= CYCLE_LIMIT);
		if (!timed_out)
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (timed_out)
			$display("timeout after %0d cycles, %0d ciphertexts outstanding",
				cyc, cipher_q.size());
		$display("covered %0d key loads and %0d block encrypts, %0d results checked",
			n_load, n_enc, n_rsp);
		$display("%0d receiver hold-offs, %0d mismatches, %0d cycles", n_holds, n_err, cyc);
		if (!timed_out && n_err == 0 && cipher_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sm4_block_encrypt.f =====
+incdir+hw/rtl
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_ram.sv
hw/rtl/sm4_round.sv
hw/rtl/sm4_block_encrypt.sv
bench/tb_sm4_block_encrypt.sv
